[rtl/psrl_pkg.sv]
// Package for the per-source rate limit filter: sizes, register reset values,
// codes, transaction and table entry types, controller state, command and status types.
// No dependencies.
package psrl_pkg;

    localparam int TRACK_ENTRIES = 1024;
    localparam int TRACK_AW      = $clog2(TRACK_ENTRIES);
    localparam int FILL_W        = $clog2(TRACK_ENTRIES + 1);
    localparam int PORT_ENTRIES  = 65536;
    localparam int PORT_AW       = $clog2(PORT_ENTRIES);
    localparam int STAMP_W       = 48;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 40;

    localparam logic [31:0] RST_PACKET_LIMIT    = 32'd1000;
    localparam logic [39:0] RST_BYTE_LIMIT      = 40'd125000000;
    localparam logic [39:0] RST_BLOCK_DURATION  = 40'd10000000000;
    localparam logic [39:0] RST_METER_WINDOW    = 40'd1000000000;
    localparam logic [39:0] RST_UDP_WINDOW      = 40'd1000000000;
    localparam logic [31:0] RST_UDP_PORT_LIMIT  = 32'd1000;
    localparam logic [15:0] RST_ICMP_SIZE_LIMIT = 16'd1000;
    localparam logic [15:0] RST_ICMP_RATE_LIMIT = 16'd100;
    localparam logic [63:0] ECHO_WINDOW_NS      = 64'd1000000000;
    localparam logic [7:0]  ICMP_ECHO_REQUEST   = 8'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DURATION  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_WINDOW    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_WINDOW      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_PORT_LIMIT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ICMP_SIZE_LIMIT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ICMP_RATE_LIMIT = 4'd7;

    localparam logic [1:0] FK_NON_IP    = 2'd0;
    localparam logic [1:0] FK_MALFORMED = 2'd1;
    localparam logic [1:0] FK_IPV4      = 2'd2;
    localparam logic [1:0] FK_IPV6      = 2'd3;

    localparam logic [1:0] TK_OTHER = 2'd0;
    localparam logic [1:0] TK_TCP   = 2'd1;
    localparam logic [1:0] TK_UDP   = 2'd2;
    localparam logic [1:0] TK_ICMP  = 2'd3;

    localparam logic [2:0] RS_PASSED    = 3'd0;
    localparam logic [2:0] RS_MALFORMED = 3'd1;
    localparam logic [2:0] RS_BLOCKED   = 3'd2;
    localparam logic [2:0] RS_RATE      = 3'd3;
    localparam logic [2:0] RS_UDP_FLOOD = 3'd4;
    localparam logic [2:0] RS_ICMP_SIZE = 3'd5;
    localparam logic [2:0] RS_ICMP_RATE = 3'd6;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [15:0] frame_length;
        logic [63:0] arrival_ns;
        logic [1:0]  transport_kind;
        logic        transport_complete;
        logic [15:0] destination_port;
        logic [7:0]  icmp_kind;
    } t_in_item;

    typedef struct packed {
        logic        verdict;
        logic [2:0]  reason;
        logic [63:0] dropped_total;
        logic [63:0] allowed_total;
    } t_out_item;

    typedef struct packed {
        logic               family;
        logic [63:0]        key_high;
        logic [63:0]        key_low;
        logic [31:0]        packets;
        logic [39:0]        bytes;
        logic [63:0]        start_ns;
        logic               block_valid;
        logic [63:0]        block_until;
        logic [STAMP_W-1:0] stamp;
    } t_src_entry;

    typedef struct packed {
        logic        valid;
        logic [31:0] count;
        logic [63:0] start_ns;
    } t_port_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EVAL_A,
        S_EVAL_B,
        S_ROUTE,
        S_PORT_RD,
        S_PORT_WR,
        S_ECHO,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_start;
        logic scan_run;
        logic eval_a;
        logic eval_b;
        logic port_read;
        logic port_write;
        logic echo;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_ip;
        logic scan_done;
        logic go_udp;
        logic go_icmp;
        logic out_free;
    } t_ctrl_sts;

endpackage

[rtl/per_source_rate_limit_filter.sv]
// Top level of the per-source rate limit filter.
// Depends on psrl_pkg, psrl_ctrl and psrl_dpath.
//
// Input channel: a descriptor transaction is taken when i_in_valid is high
// and o_in_stall is low. Output channel: one verdict transaction per input,
// held in an output register while i_out_stall is high; the next input can be
// taken while it waits. Configuration writes use i_cfg_valid/o_cfg_ready and
// are taken at any time; o_cfg_ready is always high.
// Non-IP and malformed frames skip the table scan. IP frames scan
// the source table one entry per cycle over the filled entries (up to
// 1024); UDP adds a read and write of the port table, ICMP echo adds
// the echo check. The table scan sets the throughput, one item at a time.
// Reset: after i_rst_n is released, a clearing pass writes all 65536 port
// table entries, one per cycle, with o_in_stall high for those cycles.
// A stalled output holds the result; the block finishes the item and waits.
module per_source_rate_limit_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  psrl_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output psrl_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    psrl_pkg::t_ctrl_cmd cmd;
    psrl_pkg::t_ctrl_sts sts;

    psrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    psrl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

[rtl/psrl_ctrl.sv]
// Controller state machine of the per-source rate limit filter.
// Depends on psrl_pkg.
module psrl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  psrl_pkg::t_ctrl_sts i_sts,
    output psrl_pkg::t_ctrl_cmd o_cmd
);

    psrl_pkg::t_state r_state;
    psrl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psrl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psrl_pkg::S_CLEAR: begin
                if (i_sts.clear_done) n_state = psrl_pkg::S_IDLE;
            end
            psrl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = psrl_pkg::S_DECODE;
            end
            psrl_pkg::S_DECODE: begin
                n_state = i_sts.is_ip ? psrl_pkg::S_SCAN : psrl_pkg::S_RESULT;
            end
            psrl_pkg::S_SCAN: begin
                if (i_sts.scan_done) n_state = psrl_pkg::S_EVAL_A;
            end
            psrl_pkg::S_EVAL_A: n_state = psrl_pkg::S_EVAL_B;
            psrl_pkg::S_EVAL_B: n_state = psrl_pkg::S_ROUTE;
            psrl_pkg::S_ROUTE: begin
                if (i_sts.go_udp) begin
                    n_state = psrl_pkg::S_PORT_RD;
                end else if (i_sts.go_icmp) begin
                    n_state = psrl_pkg::S_ECHO;
                end else begin
                    n_state = psrl_pkg::S_RESULT;
                end
            end
            psrl_pkg::S_PORT_RD: n_state = psrl_pkg::S_PORT_WR;
            psrl_pkg::S_PORT_WR: n_state = psrl_pkg::S_RESULT;
            psrl_pkg::S_ECHO:    n_state = psrl_pkg::S_RESULT;
            psrl_pkg::S_RESULT: begin
                if (i_sts.out_free) n_state = psrl_pkg::S_IDLE;
            end
            default: n_state = psrl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            psrl_pkg::S_CLEAR: o_cmd.clear_step = 1'b1;
            psrl_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            psrl_pkg::S_DECODE:  o_cmd.scan_start = i_sts.is_ip;
            psrl_pkg::S_SCAN:    o_cmd.scan_run   = 1'b1;
            psrl_pkg::S_EVAL_A:  o_cmd.eval_a     = 1'b1;
            psrl_pkg::S_EVAL_B:  o_cmd.eval_b     = 1'b1;
            psrl_pkg::S_ROUTE:   o_cmd            = '0;
            psrl_pkg::S_PORT_RD: o_cmd.port_read  = 1'b1;
            psrl_pkg::S_PORT_WR: o_cmd.port_write = 1'b1;
            psrl_pkg::S_ECHO:    o_cmd.echo       = 1'b1;
            psrl_pkg::S_RESULT:  o_cmd.emit       = i_sts.out_free;
            default:             o_cmd            = '0;
        endcase
    end

endmodule

[rtl/psrl_dpath.sv]
// Datapath of the per-source rate limit filter: configuration registers,
// source and port tables, meters, totals and the output register.
// Depends on psrl_pkg.
module psrl_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  psrl_pkg::t_ctrl_cmd                  i_cmd,
    output psrl_pkg::t_ctrl_sts                  o_sts,
    input  psrl_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output psrl_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    psrl_pkg::t_src_entry  src_mem [psrl_pkg::TRACK_ENTRIES];
    psrl_pkg::t_port_entry port_mem [psrl_pkg::PORT_ENTRIES];

    logic [31:0] r_packet_limit;
    logic [39:0] r_byte_limit;
    logic [39:0] r_block_duration;
    logic [39:0] r_meter_window;
    logic [39:0] r_udp_window;
    logic [31:0] r_udp_port_limit;
    logic [15:0] r_icmp_size_limit;
    logic [15:0] r_icmp_rate_limit;

    psrl_pkg::t_in_item r_item;
    logic               r_verdict;
    logic [2:0]         r_reason;
    logic [63:0]        r_drop_ctr;
    logic [63:0]        r_allow_ctr;

    logic [psrl_pkg::FILL_W-1:0]   r_fill;
    logic [psrl_pkg::STAMP_W-1:0]  r_stamp_ctr;
    logic [psrl_pkg::FILL_W-1:0]   r_scan_ptr;
    logic                          r_rd_pending;
    logic [psrl_pkg::TRACK_AW-1:0] r_rd_idx;
    psrl_pkg::t_src_entry          r_rd_ent;
    logic                          r_found;
    logic [psrl_pkg::TRACK_AW-1:0] r_match_idx;
    psrl_pkg::t_src_entry          r_match_ent;
    logic                          r_min_valid;
    logic [psrl_pkg::TRACK_AW-1:0] r_min_idx;
    logic [psrl_pkg::STAMP_W-1:0]  r_min_stamp;

    psrl_pkg::t_src_entry          r_ent;
    logic [psrl_pkg::TRACK_AW-1:0] r_ent_idx;
    logic                          r_new;
    logic                          r_blocked;
    logic [31:0]                   r_pps;
    logic [39:0]                   r_bps;

    logic [psrl_pkg::PORT_AW-1:0] r_clr_ptr;
    psrl_pkg::t_port_entry        r_port_ent;

    logic        r_echo_seen;
    logic [15:0] r_echo_count;
    logic [63:0] r_echo_start;

    logic                r_out_valid;
    psrl_pkg::t_out_item r_out_data;

    logic        fam;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] now;
    logic [15:0] len;
    logic        key_hit;
    logic        scan_issue;
    logic        table_full;
    logic [psrl_pkg::TRACK_AW-1:0] sel_idx;
    logic [psrl_pkg::PORT_AW-1:0]  port_idx;

    psrl_pkg::t_src_entry a_ent;
    logic        a_blk_active;
    logic        a_blocked;
    logic [31:0] a_pps;
    logic [39:0] a_bps;
    logic [63:0] a_elapsed;
    logic [40:0] a_sum;

    psrl_pkg::t_src_entry b_ent;
    logic        b_over;
    logic [64:0] b_until_sum;

    psrl_pkg::t_port_entry p_ent;
    logic        p_drop;
    logic [63:0] p_elapsed;

    logic [63:0] e_elapsed;
    logic        out_free;

    assign fam      = (r_item.frame_kind == psrl_pkg::FK_IPV6);
    assign key_high = fam ? r_item.source_high : 64'd0;
    assign key_low  = fam ? r_item.source_low : {32'd0, r_item.source_low[31:0]};
    assign now      = r_item.arrival_ns;
    assign len      = r_item.frame_length;
    assign port_idx = r_item.destination_port[psrl_pkg::PORT_AW-1:0];
    assign key_hit  = (r_rd_ent.family == fam) && (r_rd_ent.key_high == key_high)
                      && (r_rd_ent.key_low == key_low);
    assign scan_issue = i_cmd.scan_run && (r_scan_ptr < r_fill);
    assign table_full = (r_fill == psrl_pkg::FILL_W'(psrl_pkg::TRACK_ENTRIES));
    assign sel_idx    = r_found ? r_match_idx
                      : (table_full ? r_min_idx : r_fill[psrl_pkg::TRACK_AW-1:0]);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_sts.clear_done = (r_clr_ptr == {psrl_pkg::PORT_AW{1'b1}});
    assign o_sts.is_ip      = (r_item.frame_kind == psrl_pkg::FK_IPV4)
                              || (r_item.frame_kind == psrl_pkg::FK_IPV6);
    assign o_sts.scan_done  = !r_rd_pending && (r_scan_ptr == r_fill);
    assign o_sts.go_udp     = !r_verdict && r_item.transport_complete
                              && (r_item.transport_kind == psrl_pkg::TK_UDP);
    assign o_sts.go_icmp    = !r_verdict && r_item.transport_complete
                              && (r_item.transport_kind == psrl_pkg::TK_ICMP)
                              && !fam && (r_item.icmp_kind == psrl_pkg::ICMP_ECHO_REQUEST);
    assign o_sts.out_free   = out_free;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_limit    <= psrl_pkg::RST_PACKET_LIMIT;
            r_byte_limit      <= psrl_pkg::RST_BYTE_LIMIT;
            r_block_duration  <= psrl_pkg::RST_BLOCK_DURATION;
            r_meter_window    <= psrl_pkg::RST_METER_WINDOW;
            r_udp_window      <= psrl_pkg::RST_UDP_WINDOW;
            r_udp_port_limit  <= psrl_pkg::RST_UDP_PORT_LIMIT;
            r_icmp_size_limit <= psrl_pkg::RST_ICMP_SIZE_LIMIT;
            r_icmp_rate_limit <= psrl_pkg::RST_ICMP_RATE_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psrl_pkg::CFG_PACKET_LIMIT:    r_packet_limit    <= i_cfg_data[31:0];
                psrl_pkg::CFG_BYTE_LIMIT:      r_byte_limit      <= i_cfg_data;
                psrl_pkg::CFG_BLOCK_DURATION:  r_block_duration  <= i_cfg_data;
                psrl_pkg::CFG_METER_WINDOW:    r_meter_window    <= i_cfg_data;
                psrl_pkg::CFG_UDP_WINDOW:      r_udp_window      <= i_cfg_data;
                psrl_pkg::CFG_UDP_PORT_LIMIT:  r_udp_port_limit  <= i_cfg_data[31:0];
                psrl_pkg::CFG_ICMP_SIZE_LIMIT: r_icmp_size_limit <= i_cfg_data[15:0];
                psrl_pkg::CFG_ICMP_RATE_LIMIT: r_icmp_rate_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_rd_ent <= src_mem[r_scan_ptr[psrl_pkg::TRACK_AW-1:0]];
        end
        if (i_cmd.eval_b) begin
            src_mem[r_ent_idx] <= b_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            port_mem[r_clr_ptr] <= '0;
        end else if (i_cmd.port_write) begin
            port_mem[port_idx] <= p_ent;
        end
        if (i_cmd.port_read) begin
            r_port_ent <= port_mem[port_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pending <= 1'b0;
            r_scan_ptr   <= '0;
        end else if (i_cmd.scan_start) begin
            r_rd_pending <= 1'b0;
            r_scan_ptr   <= '0;
            r_found      <= 1'b0;
            r_min_valid  <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_rd_pending <= scan_issue;
            if (scan_issue) begin
                r_rd_idx   <= r_scan_ptr[psrl_pkg::TRACK_AW-1:0];
                r_scan_ptr <= r_scan_ptr + 1'b1;
            end
            if (r_rd_pending) begin
                if (key_hit) begin
                    r_found     <= 1'b1;
                    r_match_idx <= r_rd_idx;
                    r_match_ent <= r_rd_ent;
                end
                if (!r_min_valid || (r_rd_ent.stamp < r_min_stamp)) begin
                    r_min_valid <= 1'b1;
                    r_min_idx   <= r_rd_idx;
                    r_min_stamp <= r_rd_ent.stamp;
                end
            end
        end
    end

    assign a_blk_active = r_match_ent.block_valid && (r_match_ent.block_until != 64'd0);
    assign a_elapsed    = now - r_match_ent.start_ns;

    always_comb begin
        a_ent     = r_match_ent;
        a_blocked = 1'b0;
        a_pps     = '0;
        a_bps     = '0;
        a_sum     = '0;
        if (!r_found) begin
            a_ent.family      = fam;
            a_ent.key_high    = key_high;
            a_ent.key_low     = key_low;
            a_ent.block_valid = 1'b0;
            a_ent.block_until = '0;
            a_ent.packets     = 32'd1;
            a_ent.bytes       = {24'd0, len};
            a_ent.start_ns    = now;
            a_pps             = 32'd1;
            a_bps             = {24'd0, len};
        end else if (a_blk_active && (now <= r_match_ent.block_until)) begin
            a_blocked = 1'b1;
        end else begin
            if (a_blk_active) begin
                a_ent.block_valid = 1'b0;
            end
            if (a_elapsed > {24'd0, r_meter_window}) begin
                a_ent.packets  = '0;
                a_ent.bytes    = '0;
                a_ent.start_ns = now;
            end else begin
                if (a_ent.packets != 32'hFFFF_FFFF) begin
                    a_ent.packets = a_ent.packets + 32'd1;
                end
                a_sum       = {1'b0, a_ent.bytes} + {25'd0, len};
                a_ent.bytes = a_sum[40] ? {40{1'b1}} : a_sum[39:0];
                a_pps       = a_ent.packets;
                a_bps       = a_ent.bytes;
            end
        end
        a_ent.stamp = r_stamp_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_a) begin
            r_ent     <= a_ent;
            r_ent_idx <= sel_idx;
            r_new     <= !r_found;
            r_blocked <= a_blocked;
            r_pps     <= a_pps;
            r_bps     <= a_bps;
        end
    end

    assign b_over      = (r_pps > r_packet_limit) || (r_bps > r_byte_limit);
    assign b_until_sum = {1'b0, now} + {25'd0, r_block_duration};

    always_comb begin
        b_ent = r_ent;
        if (!r_blocked && b_over) begin
            b_ent.block_valid = 1'b1;
            b_ent.block_until = b_until_sum[64] ? {64{1'b1}} : b_until_sum[63:0];
        end
    end

    assign p_elapsed = now - r_port_ent.start_ns;

    always_comb begin
        p_ent  = r_port_ent;
        p_drop = 1'b0;
        if (r_port_ent.valid && (p_elapsed < {24'd0, r_udp_window})) begin
            if (p_ent.count != 32'hFFFF_FFFF) begin
                p_ent.count = p_ent.count + 32'd1;
            end
            p_drop = (p_ent.count > r_udp_port_limit);
        end else begin
            p_ent.valid    = 1'b1;
            p_ent.count    = 32'd1;
            p_ent.start_ns = now;
        end
    end

    assign e_elapsed = now - r_echo_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_stamp_ctr <= '0;
            r_drop_ctr  <= '0;
            r_allow_ctr <= '0;
            r_echo_seen  <= 1'b0;
            r_echo_count <= '0;
            r_echo_start <= '0;
        end else begin
            if (i_cmd.load) begin
                r_verdict <= (i_in_data.frame_kind == psrl_pkg::FK_MALFORMED);
                r_reason  <= (i_in_data.frame_kind == psrl_pkg::FK_MALFORMED)
                             ? psrl_pkg::RS_MALFORMED : psrl_pkg::RS_PASSED;
            end
            if (i_cmd.eval_b) begin
                r_stamp_ctr <= r_stamp_ctr + 1'b1;
                if (r_new && !table_full) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_blocked || b_over) begin
                    if (r_drop_ctr != {64{1'b1}}) r_drop_ctr <= r_drop_ctr + 64'd1;
                    r_verdict <= 1'b1;
                    r_reason  <= r_blocked ? psrl_pkg::RS_BLOCKED : psrl_pkg::RS_RATE;
                end else if (r_allow_ctr != {64{1'b1}}) begin
                    r_allow_ctr <= r_allow_ctr + 64'd1;
                end
            end
            if (i_cmd.port_write && p_drop) begin
                r_verdict <= 1'b1;
                r_reason  <= psrl_pkg::RS_UDP_FLOOD;
            end
            if (i_cmd.echo) begin
                if (len > r_icmp_size_limit) begin
                    r_verdict <= 1'b1;
                    r_reason  <= psrl_pkg::RS_ICMP_SIZE;
                end else if (!r_echo_seen || (e_elapsed >= psrl_pkg::ECHO_WINDOW_NS)) begin
                    r_echo_seen  <= 1'b1;
                    r_echo_count <= 16'd1;
                    r_echo_start <= now;
                end else if (r_echo_count >= r_icmp_rate_limit) begin
                    r_verdict <= 1'b1;
                    r_reason  <= psrl_pkg::RS_ICMP_RATE;
                end else begin
                    r_echo_count <= r_echo_count + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.verdict       <= r_verdict;
            r_out_data.reason        <= r_reason;
            r_out_data.dropped_total <= r_drop_ctr;
            r_out_data.allowed_total <= r_allow_ctr;
        end
    end

`ifndef ASSERT_OFF
    a_verdict_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.verdict == (r_out_data.reason != psrl_pkg::RS_PASSED)))
        else $error("verdict and reason disagree");
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= psrl_pkg::FILL_W'(psrl_pkg::TRACK_ENTRIES))
        else $error("fill count past table size");
    a_scan_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pending |-> ({1'b0, r_rd_idx} < r_fill))
        else $error("scan read beyond filled entries");
    a_fill_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.eval_b |=> $stable(r_fill))
        else $error("fill count changed outside entry commit");
`endif

endmodule
